/* rtl/two_pool_free_page_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Two-pool free page allocator: assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TWO_POOL_FREE_PAGE_ALLOCATOR_DEFINES_SVH
`define TWO_POOL_FREE_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TPFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpfa check failed");
// next-cycle implication
`define TPFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpfa check failed");
`else
`define TPFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/tpfa_pkg.sv */
// ----------------------------------------------------------------------------
// tpfa_pkg
// Types, codes and sizing for the two-pool free page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpfa_pkg;

    localparam int TOTAL_PAGES       = 1024;
    localparam int KERNEL_POOL_PAGES = 256;

    // kernel pool is cut to the store size
    localparam int KERN_EFF    = (KERNEL_POOL_PAGES > TOTAL_PAGES) ?
                                 TOTAL_PAGES : KERNEL_POOL_PAGES;
    localparam int USER_EFF    = TOTAL_PAGES - KERN_EFF;

    localparam int PAGE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int COUNT_MAX   = 2047;
    localparam int ADDR_W      = $clog2(TOTAL_PAGES);
    localparam int IDX_W       = $clog2(TOTAL_PAGES + 1);

    localparam int KERN_CNT_RST = (KERN_EFF > COUNT_MAX) ? COUNT_MAX : KERN_EFF;
    localparam int USER_CNT_RST = (USER_EFF > COUNT_MAX) ? COUNT_MAX : USER_EFF;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_FREE    = 1'b1;
    localparam logic POOL_USER    = 1'b0;
    localparam logic POOL_KERN    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              pool;
        logic [PAGE_W-1:0] page_index;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] granted_page;
        logic [CNT_W-1:0]  free_count;
    } t_result;

    // one link: successor page and whether there is one
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_link             data;
    } t_mem_wr;

endpackage

/* rtl/tpfa_ram.sv */
// ----------------------------------------------------------------------------
// tpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tpfa_init.sv */
// ----------------------------------------------------------------------------
// tpfa_init
// Post-reset sweep that chains every pool in ascending page order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfa_init (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output tpfa_pkg::t_mem_wr o_wr,
    output logic              o_done
);

    logic [tpfa_pkg::IDX_W-1:0] r_idx;
    logic [tpfa_pkg::IDX_W-1:0] n_idx;
    logic                       w_last;

    assign o_done = (r_idx == tpfa_pkg::IDX_W'(tpfa_pkg::TOTAL_PAGES));
    assign n_idx  = r_idx + 1'b1;

    // last page of either pool has no successor
    assign w_last = (n_idx == tpfa_pkg::IDX_W'(tpfa_pkg::KERN_EFF)) ||
                    (n_idx == tpfa_pkg::IDX_W'(tpfa_pkg::TOTAL_PAGES));

    always_comb begin
        o_wr.en         = !o_done;
        o_wr.addr       = r_idx[tpfa_pkg::ADDR_W-1:0];
        o_wr.data.valid = !w_last;
        o_wr.data.page  = w_last ? '0 : n_idx[tpfa_pkg::PAGE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (!o_done) begin
            r_idx <= n_idx;
        end
    end

endmodule

/* rtl/tpfa_ctrl.sv */
// ----------------------------------------------------------------------------
// tpfa_ctrl
// Pool heads, free counts and the pop/push sequencer around the link store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpfa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_init_done,
    input  logic                        i_start,
    input  tpfa_pkg::t_req              i_req,
    output logic                        o_busy,
    output tpfa_pkg::t_mem_wr           o_wr,
    output logic                        o_re,
    output logic [tpfa_pkg::ADDR_W-1:0] o_raddr,
    input  tpfa_pkg::t_link             i_rdata,
    output logic                        o_valid,
    output tpfa_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    tpfa_pkg::t_link            r_head [2];
    tpfa_pkg::t_link            n_head [2];
    logic [tpfa_pkg::CNT_W-1:0] r_cnt  [2];
    logic [tpfa_pkg::CNT_W-1:0] n_cnt  [2];
    logic                       r_pool, n_pool;
    logic [tpfa_pkg::PAGE_W-1:0] r_page, n_page;
    logic                       r_valid, n_valid;
    tpfa_pkg::t_result          r_result, n_result;

    logic                       w_accept;
    tpfa_pkg::t_link            w_head;
    logic [tpfa_pkg::CNT_W-1:0] w_cnt;

    assign o_busy   = (r_state != ST_IDLE) || !i_init_done;
    assign w_accept = i_start && !o_busy;
    assign w_head   = r_head[i_req.pool];
    assign w_cnt    = r_cnt[i_req.pool];

    // head link is fetched on every accept; used only by a pop
    assign o_re    = w_accept;
    assign o_raddr = w_head.page[tpfa_pkg::ADDR_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_pool   = r_pool;
        n_page   = r_page;
        n_valid  = 1'b0;
        n_result = r_result;
        o_wr     = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pool = i_req.pool;
                    if (i_req.mode == tpfa_pkg::MODE_ALLOC) begin
                        if (!w_head.valid || ({1'b0, w_head.page} >=
                                tpfa_pkg::CNT_W'(tpfa_pkg::TOTAL_PAGES))) begin
                            n_valid               = 1'b1;
                            n_result.status       = tpfa_pkg::STATUS_EMPTY;
                            n_result.granted_page = '0;
                            n_result.free_count   = w_cnt;
                        end else begin
                            n_page  = w_head.page;
                            n_state = ST_READ;
                        end
                    end else begin
                        n_valid               = 1'b1;
                        n_result.status       = tpfa_pkg::STATUS_OK;
                        n_result.granted_page = '0;
                        n_result.free_count   = w_cnt;
                        if ({1'b0, i_req.page_index} <
                                tpfa_pkg::CNT_W'(tpfa_pkg::TOTAL_PAGES)) begin
                            // push: new page links to the old head
                            o_wr.en   = 1'b1;
                            o_wr.addr = i_req.page_index[tpfa_pkg::ADDR_W-1:0];
                            o_wr.data = w_head;
                            n_head[i_req.pool].valid = 1'b1;
                            n_head[i_req.pool].page  = i_req.page_index;
                            if (w_cnt != tpfa_pkg::CNT_W'(tpfa_pkg::COUNT_MAX)) begin
                                n_cnt[i_req.pool]   = w_cnt + 1'b1;
                                n_result.free_count = w_cnt + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                // link of the popped page is now the new head
                n_head[r_pool]        = i_rdata;
                n_valid               = 1'b1;
                n_result.status       = tpfa_pkg::STATUS_OK;
                n_result.granted_page = r_page;
                n_result.free_count   = r_cnt[r_pool];
                if (r_cnt[r_pool] != '0) begin
                    n_cnt[r_pool]       = r_cnt[r_pool] - 1'b1;
                    n_result.free_count = r_cnt[r_pool] - 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                          <= ST_IDLE;
            r_valid                          <= 1'b0;
            r_head[tpfa_pkg::POOL_KERN].valid <= (tpfa_pkg::KERN_EFF > 0);
            r_head[tpfa_pkg::POOL_KERN].page  <= '0;
            r_head[tpfa_pkg::POOL_USER].valid <= (tpfa_pkg::KERN_EFF < tpfa_pkg::TOTAL_PAGES);
            r_head[tpfa_pkg::POOL_USER].page  <=
                (tpfa_pkg::KERN_EFF < tpfa_pkg::TOTAL_PAGES) ?
                tpfa_pkg::PAGE_W'(tpfa_pkg::KERN_EFF) : '0;
            r_cnt[tpfa_pkg::POOL_KERN]        <= tpfa_pkg::CNT_W'(tpfa_pkg::KERN_CNT_RST);
            r_cnt[tpfa_pkg::POOL_USER]        <= tpfa_pkg::CNT_W'(tpfa_pkg::USER_CNT_RST);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool   <= n_pool;
        r_page   <= n_page;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/two_pool_free_page_allocator.sv */
// ----------------------------------------------------------------------------
// two_pool_free_page_allocator
// Kernel and user LIFO free lists threaded through one link RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps all TOTAL_PAGES (1024) entries of the link RAM to
// chain both pools in ascending order; busy stays high until that is done.
// A word is taken when start is high and busy low. A free, an allocate from
// an empty pool, and a free of a page beyond the store give their result in
// the next cycle, and the next word may follow at once. A successful allocate
// goes through ST_READ: the link of the head page has to come back from the
// registered-read link RAM before the new head is known, so busy is high
// in ST_READ. Each result sits on o_result for one cycle with o_valid high
// and must be taken then; there is no back-pressure.
`timescale 1ns / 1ps
`include "two_pool_free_page_allocator_defines.svh"

module two_pool_free_page_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  tpfa_pkg::t_req      i_req,
    output logic                busy,
    output logic                o_valid,
    output tpfa_pkg::t_result   o_result
);

    tpfa_pkg::t_mem_wr           w_init_wr;
    tpfa_pkg::t_mem_wr           w_ctrl_wr;
    tpfa_pkg::t_mem_wr           w_wr;
    logic                        w_init_done;
    logic                        w_re;
    logic [tpfa_pkg::ADDR_W-1:0] w_raddr;
    tpfa_pkg::t_link             w_rdata;

    tpfa_init u_init (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (w_init_wr),
        .o_done  (w_init_done)
    );

    tpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_done (w_init_done),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_wr        (w_ctrl_wr),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // sweep owns the write port until the chains are laid
    assign w_wr = w_init_done ? w_ctrl_wr : w_init_wr;

    tpfa_ram #(
        .WIDTH (tpfa_pkg::LINK_W),
        .DEPTH (tpfa_pkg::TOTAL_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `TPFA_ASSERT_NXT(a_free_one_cycle, i_clk, i_rst_n, start && !busy && (i_req.mode == tpfa_pkg::MODE_FREE), o_valid)
    `TPFA_ASSERT_IMP(a_no_ctrl_wr_in_sweep, i_clk, i_rst_n, !w_init_done, !w_ctrl_wr.en && busy)
    `TPFA_ASSERT_IMP(a_empty_grants_zero, i_clk, i_rst_n, o_valid && (o_result.status == tpfa_pkg::STATUS_EMPTY), o_result.granted_page == '0)
    `TPFA_ASSERT_NXT(a_pop_then_result, i_clk, i_rst_n, busy && w_init_done, o_valid && !busy)

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: two-pool free page allocator testbench
// Sends allocate and free words to both pools and predicts each result from a
// local copy of the link store, heads and free counts. Covers draining each
// pool to empty, LIFO reuse, double and foreign frees, the count held at zero,
// and a random mix with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 260;

    typedef struct packed {
        logic                        pool;
        logic [tpfa_pkg::PAGE_W-1:0] page;
    } t_held;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    tpfa_pkg::t_req    i_req   = '0;
    logic              busy;
    logic              o_valid;
    tpfa_pkg::t_result o_result;

    // predicted allocator state
    tpfa_pkg::t_link   link_mem [tpfa_pkg::TOTAL_PAGES];
    tpfa_pkg::t_link   kern_head;
    tpfa_pkg::t_link   user_head;
    int                kern_cnt;
    int                user_cnt;

    tpfa_pkg::t_result expected_grants[$];
    t_held             held_pages[$];
    int                errors     = 0;
    int                cycles     = 0;
    int                words_sent = 0;
    bit                no_idle    = 1'b0;

    two_pool_free_page_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void reset_pools();
        int  kern;
        bit  last;
        kern = (tpfa_pkg::KERNEL_POOL_PAGES > tpfa_pkg::TOTAL_PAGES) ?
               tpfa_pkg::TOTAL_PAGES : tpfa_pkg::KERNEL_POOL_PAGES;
        for (int i = 0; i < tpfa_pkg::TOTAL_PAGES; i++) begin
            last = (i + 1 == kern) || (i + 1 == tpfa_pkg::TOTAL_PAGES);
            link_mem[i].valid = !last;
            link_mem[i].page  = last ? '0 : tpfa_pkg::PAGE_W'(i + 1);
        end
        kern_head.valid = kern > 0;
        kern_head.page  = '0;
        user_head.valid = kern < tpfa_pkg::TOTAL_PAGES;
        user_head.page  = (kern < tpfa_pkg::TOTAL_PAGES) ? tpfa_pkg::PAGE_W'(kern) : '0;
        kern_cnt = (kern > tpfa_pkg::COUNT_MAX) ? tpfa_pkg::COUNT_MAX : kern;
        user_cnt = (tpfa_pkg::TOTAL_PAGES - kern > tpfa_pkg::COUNT_MAX) ?
                   tpfa_pkg::COUNT_MAX : tpfa_pkg::TOTAL_PAGES - kern;
    endfunction

    // pop or push on the chosen pool; returns the result the block should give
    function automatic tpfa_pkg::t_result predict_grant(tpfa_pkg::t_req req);
        tpfa_pkg::t_link   head;
        int                cnt;
        tpfa_pkg::t_result res;
        head = (req.pool == tpfa_pkg::POOL_KERN) ? kern_head : user_head;
        cnt  = (req.pool == tpfa_pkg::POOL_KERN) ? kern_cnt : user_cnt;
        res  = '0;
        res.status = tpfa_pkg::STATUS_OK;
        if (req.mode == tpfa_pkg::MODE_ALLOC) begin
            if (!head.valid || int'(head.page) >= tpfa_pkg::TOTAL_PAGES) begin
                res.status = tpfa_pkg::STATUS_EMPTY;
            end else begin
                res.granted_page = head.page;
                head = link_mem[head.page];
                if (cnt > 0) cnt--;
            end
        end else if (int'(req.page_index) < tpfa_pkg::TOTAL_PAGES) begin
            link_mem[req.page_index] = head;
            head.valid = 1'b1;
            head.page  = req.page_index;
            cnt = (cnt + 1 > tpfa_pkg::COUNT_MAX) ? tpfa_pkg::COUNT_MAX : cnt + 1;
        end
        if (req.pool == tpfa_pkg::POOL_KERN) begin
            kern_head = head;
            kern_cnt  = cnt;
        end else begin
            user_head = head;
            user_cnt  = cnt;
        end
        res.free_count = tpfa_pkg::CNT_W'(cnt);
        return res;
    endfunction

    function automatic tpfa_pkg::t_req make_req(logic mode, logic pool,
                                                logic [tpfa_pkg::PAGE_W-1:0] page);
        tpfa_pkg::t_req req;
        req.mode       = mode;
        req.pool       = pool;
        req.page_index = page;
        return req;
    endfunction

    // start stays high across back-to-back words; lowered only for a gap
    task automatic send_word(tpfa_pkg::t_req req);
        int                gap;
        tpfa_pkg::t_result res;
        if (words_sent % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        // busy only moves at a rising edge: low at the falling edge means
        // the word is taken at the next rising edge
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        res = predict_grant(req);
        expected_grants.push_back(res);
        if (req.mode == tpfa_pkg::MODE_ALLOC && res.status == tpfa_pkg::STATUS_OK)
            held_pages.push_back({req.pool, res.granted_page});
        words_sent++;
    endtask

    always @(posedge i_clk) begin : check_results
        tpfa_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, o_result);
            end else begin
                want = expected_grants.pop_front();
                if (o_result.status !== want.status) begin
                    errors++;
                    $display("%0t: status: expected %0d, actual %0d",
                             $time, want.status, o_result.status);
                end
                if (o_result.granted_page !== want.granted_page) begin
                    errors++;
                    $display("%0t: granted_page: expected %0d, actual %0d",
                             $time, want.granted_page, o_result.granted_page);
                end
                if (o_result.free_count !== want.free_count) begin
                    errors++;
                    $display("%0t: free_count: expected %0d, actual %0d",
                             $time, want.free_count, o_result.free_count);
                end
            end
        end
    end

    // drain each pool through its whole chain, then ask an empty pool twice
    task automatic test_empty_pools();
        int n;
        n = 0;
        while (kern_head.valid && n < 2 * tpfa_pkg::TOTAL_PAGES) begin
            send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_KERN,
                               tpfa_pkg::PAGE_W'($urandom)));
            n++;
        end
        repeat (2) send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_KERN,
                                      tpfa_pkg::PAGE_W'($urandom)));
        n = 0;
        while (user_head.valid && n < 2 * tpfa_pkg::TOTAL_PAGES) begin
            send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER,
                               tpfa_pkg::PAGE_W'($urandom)));
            n++;
        end
        repeat (2) send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER,
                                      tpfa_pkg::PAGE_W'($urandom)));
    endtask

    task automatic test_directed();
        // extreme pages, page_index ignored on allocate
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_KERN, '0));
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_USER, '1));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_KERN, '1));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER, '0));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER, '1));
        // LIFO order on reuse
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_USER, '1));
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_USER, '0));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER, '0));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER, '0));
        // foreign page: a kernel-range page pushed onto the user pool
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_USER,
                           tpfa_pkg::PAGE_W'(10)));
        send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_USER, '0));
        // double free makes a self loop; third allocate holds the count at 0
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_KERN,
                           tpfa_pkg::PAGE_W'(5)));
        send_word(make_req(tpfa_pkg::MODE_FREE,  tpfa_pkg::POOL_KERN,
                           tpfa_pkg::PAGE_W'(5)));
        repeat (3) send_word(make_req(tpfa_pkg::MODE_ALLOC, tpfa_pkg::POOL_KERN,
                                      tpfa_pkg::PAGE_W'($urandom)));
    endtask

    // allocates, frees of pages that were handed out, and noise frees
    task automatic test_random();
        int    pick;
        int    idx;
        t_held h;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85 && pick >= 40 && held_pages.size() != 0) begin
                idx = $urandom_range(0, held_pages.size() - 1);
                h = held_pages[idx];
                held_pages.delete(idx);
                send_word(make_req(tpfa_pkg::MODE_FREE, h.pool, h.page));
            end else if (pick >= 85) begin
                send_word(make_req(tpfa_pkg::MODE_FREE, 1'($urandom),
                                   tpfa_pkg::PAGE_W'($urandom)));
            end else begin
                send_word(make_req(tpfa_pkg::MODE_ALLOC, 1'($urandom),
                                   tpfa_pkg::PAGE_W'($urandom)));
            end
        end
    endtask

    initial begin
        reset_pools();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_pools();
        test_directed();
        test_random();
        start <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* two_pool_free_page_allocator.f */
+incdir+rtl
rtl/tpfa_pkg.sv
rtl/tpfa_ram.sv
rtl/tpfa_init.sv
rtl/tpfa_ctrl.sv
rtl/two_pool_free_page_allocator.sv
sim/tb_top.sv
